>>> rtl/core/dcbrm_pkg.sv
package dcbrm_pkg;

    localparam int REQ_W    = 3;
    localparam int IDX_W    = 3;
    localparam int LEASE_W  = 32;
    localparam int HFIRST_W = 48;
    localparam int ASAMP_W  = 16;
    localparam int STAT_W   = 3;
    localparam int DEST_W   = 4;
    localparam int CNT_W    = 4;
    localparam int ERR_W    = 32;
    localparam int LOST_W   = 48;
    localparam int BST_W    = 3;

    localparam logic [REQ_W-1:0] REQ_PRIME   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_FRAME   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ACQUIRE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_STOP    = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOT_RUNNING = 3'd1;
    localparam logic [STAT_W-1:0] ST_ALREADY     = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_QUIET   = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD_COMPL   = 3'd4;
    localparam logic [STAT_W-1:0] ST_NONE_READY  = 3'd5;
    localparam logic [STAT_W-1:0] ST_BAD_HANDLE  = 3'd6;

    localparam logic [BST_W-1:0] B_FREE    = 3'd0;
    localparam logic [BST_W-1:0] B_QUEUED  = 3'd1;
    localparam logic [BST_W-1:0] B_ACTIVE  = 3'd2;
    localparam logic [BST_W-1:0] B_READY   = 3'd3;
    localparam logic [BST_W-1:0] B_PACKING = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [IDX_W-1:0]    handle_index;
        logic [LEASE_W-1:0]  handle_lease;
        logic [HFIRST_W-1:0] handle_first_sample;
        logic [ASAMP_W-1:0]  stop_samples;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [DEST_W-1:0]   active_dest;
        logic [DEST_W-1:0]   queued_dest;
        logic [DEST_W-1:0]   dest_index;
        logic [HFIRST_W-1:0] start_sample;
        logic [LEASE_W-1:0]  lease_id;
        logic [CNT_W-1:0]    ready_count;
        logic [CNT_W-1:0]    busy_count;
        logic                running;
        logic [ERR_W-1:0]    fault_count;
        logic [ERR_W-1:0]    overruns;
        logic [LOST_W-1:0]   lost_total;
    } t_rsp;

    typedef enum logic [3:0] {
        OP_IDLE, OP_LOAD, OP_SCAN, OP_EXEC, OP_TAKE1, OP_TAKE2, OP_FRAME2,
        OP_COUNT, OP_DONE
    } t_op;

    typedef struct packed {
        t_op  op;
        logic scan_start;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic count_done;
    } t_sts;

endpackage

>>> rtl/core/dcbrm_if.sv
interface dcbrm_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/dcbrm_ctrl.sv
module dcbrm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  logic [2:0]        i_req_type,
    input  dcbrm_pkg::t_sts   i_sts,
    output dcbrm_pkg::t_cmd   o_cmd
);
    import dcbrm_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_EXEC, S_T1, S_T2, S_F2, S_CNT, S_OUT} t_state;
    t_state r_state;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        o_cmd.scan_start = 1'b0;
        o_cmd.op = OP_IDLE;
        case (r_state)
            S_IDLE: begin
                o_cmd.op = OP_LOAD;
                o_cmd.scan_start = i_in_valid;
            end
            S_SCAN: o_cmd.op = OP_SCAN;
            S_EXEC: o_cmd.op = OP_EXEC;
            S_T1:   o_cmd.op = OP_TAKE1;
            S_T2:   o_cmd.op = OP_TAKE2;
            S_F2:   o_cmd.op = OP_FRAME2;
            S_CNT:  o_cmd.op = OP_COUNT;
            S_OUT:  o_cmd.op = OP_DONE;
            default: o_cmd.op = OP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: if (i_in_valid) r_state <= S_SCAN;
                S_SCAN: if (i_sts.scan_done) r_state <= S_EXEC;
                S_EXEC: begin
                    r_state <= S_CNT;
                    if (i_req_type == REQ_PRIME) r_state <= S_T1;
                    if (i_req_type == REQ_FRAME) r_state <= S_F2;
                end
                S_T1: r_state <= S_T2;
                S_T2: r_state <= S_CNT;
                S_F2: r_state <= S_CNT;
                S_CNT: if (i_sts.count_done) r_state <= S_OUT;
                S_OUT: if (i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/core/dcbrm_dp.sv
module dcbrm_dp #(
    parameter int RING_DEPTH        = 8,
    parameter int SAMPLES_PER_FRAME = 1024,
    parameter int SAMPLE_BITS       = 48
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dcbrm_pkg::t_req   i_req,
    input  dcbrm_pkg::t_cmd   i_cmd,
    output dcbrm_pkg::t_sts   o_sts,
    output logic [2:0]        o_req_type,
    output dcbrm_pkg::t_rsp   o_rsp
);
    import dcbrm_pkg::*;

    localparam int PW = $clog2(RING_DEPTH);
    localparam int SW = SAMPLE_BITS;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam logic [DEST_W-1:0] D_OVF  = DEST_W'(RING_DEPTH);
    localparam logic [DEST_W-1:0] D_NONE = DEST_W'(RING_DEPTH + 1);
    localparam logic [SW-1:0] S_MAX = {SW{1'b1}};
    localparam logic [SW-1:0] SPF = SW'(SAMPLES_PER_FRAME);
    localparam logic [LOST_W-1:0] LPF = LOST_W'(SAMPLES_PER_FRAME);

    t_req r_req;
    logic [BST_W-1:0]   r_bst [RING_DEPTH];
    logic [SW-1:0]      r_bfs [RING_DEPTH];
    logic [LEASE_W-1:0] r_bls [RING_DEPTH];
    logic r_run;
    logic [DEST_W-1:0] r_cur, r_nxt;
    logic [SW-1:0] r_curf, r_nxtf, r_futf;
    logic [PW-1:0] r_sptr;
    logic [LEASE_W-1:0] r_lc;
    logic [ERR_W-1:0] r_err, r_ovr;
    logic [LOST_W-1:0] r_lost;
    logic [STAT_W-1:0] r_stat;
    logic [DEST_W-1:0] r_bidx;
    logic [SW-1:0] r_bfirst;
    logic [LEASE_W-1:0] r_lease;
    logic r_abort;
    logic [PW:0] r_i;
    logic r_found;
    logic [PW-1:0] r_sel;
    logic r_ffound;
    logic [PW-1:0] r_fsel;
    logic r_allfree;
    logic [CW-1:0] r_nrdy, r_npk;

    logic [PW-1:0] w_i;
    logic [PW-1:0] w_fc;
    logic [PW:0] w_fsum;
    logic [PW-1:0] w_cur, w_nxt;

    assign w_i = r_i[PW-1:0];
    assign w_fsum = {1'b0, r_sptr} + r_i;
    assign w_fc = (w_fsum >= (PW+1)'(RING_DEPTH)) ? PW'(w_fsum - (PW+1)'(RING_DEPTH))
                                                    : w_fsum[PW-1:0];
    assign w_cur = r_cur[PW-1:0];
    assign w_nxt = r_nxt[PW-1:0];
    assign o_req_type = r_req.req_type;
    assign o_sts.scan_done  = (r_i == (PW+1)'(RING_DEPTH - 1));
    assign o_sts.count_done = (r_i == (PW+1)'(RING_DEPTH - 1));

    function automatic logic [ERR_W-1:0] inc32(input logic [ERR_W-1:0] v);
        return (v == {ERR_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic logic [LOST_W-1:0] addl(input logic [LOST_W-1:0] v,
                                              input logic [LOST_W-1:0] a);
        logic [LOST_W:0] s;
        s = {1'b0, v} + {1'b0, a};
        return s[LOST_W] ? {LOST_W{1'b1}} : s[LOST_W-1:0];
    endfunction

    function automatic logic [SW-1:0] adds(input logic [SW-1:0] v);
        logic [SW:0] s;
        s = {1'b0, v} + {1'b0, SPF};
        return s[SW] ? S_MAX : s[SW-1:0];
    endfunction

    function automatic logic [PW-1:0] incp(input logic [PW-1:0] v);
        return (v == PW'(RING_DEPTH - 1)) ? '0 : v + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RING_DEPTH; k++) begin
                r_bst[k] <= B_FREE;
                r_bls[k] <= '0;
            end
            r_run <= 1'b0;
            r_cur <= D_NONE;
            r_nxt <= D_NONE;
            r_curf <= '0;
            r_nxtf <= '0;
            r_futf <= '0;
            r_sptr <= '0;
            r_lc <= 32'd1;
            r_err <= '0;
            r_ovr <= '0;
            r_lost <= '0;
            r_i <= '0;
        end else begin
            case (i_cmd.op)
                OP_LOAD: if (i_cmd.scan_start) begin
                    r_req <= i_req;
                    r_i <= '0;
                    r_found <= 1'b0;
                    r_sel <= '0;
                    r_ffound <= 1'b0;
                    r_fsel <= '0;
                    r_allfree <= 1'b1;
                    r_stat <= ST_OK;
                    r_bidx <= D_NONE;
                    r_bfirst <= '0;
                    r_lease <= '0;
                    r_abort <= 1'b0;
                end
                OP_SCAN: begin
                    // oldest ready buffer and all-free check
                    if (r_bst[w_i] != B_FREE) r_allfree <= 1'b0;
                    if (r_bst[w_i] == B_READY &&
                        (!r_found || r_bfs[w_i] < r_bfs[r_sel])) begin
                        r_found <= 1'b1;
                        r_sel <= w_i;
                    end
                    r_i <= o_sts.scan_done ? '0 : r_i + 1'b1;
                end
                OP_EXEC: begin
                    case (r_req.req_type)
                        REQ_PRIME: begin
                            if (r_run) r_stat <= ST_ALREADY;
                            else if (!r_allfree) r_stat <= ST_NOT_QUIET;
                            else begin
                                r_err <= '0;
                                r_ovr <= '0;
                                r_lost <= '0;
                                r_sptr <= '0;
                                r_curf <= '0;
                                r_nxtf <= SPF;
                                r_futf <= adds(SPF);
                                r_run <= 1'b1;
                            end
                        end
                        REQ_FRAME: begin
                            r_bidx <= r_cur;
                            r_bfirst <= r_curf;
                            if (!r_run) begin
                                r_stat <= ST_NOT_RUNNING;
                                r_abort <= 1'b1;
                            end else if (r_cur < D_OVF) begin
                                if (r_bst[w_cur] != B_ACTIVE) begin
                                    r_err <= inc32(r_err);
                                    r_stat <= ST_BAD_COMPL;
                                    r_abort <= 1'b1;
                                end else r_bst[w_cur] <= B_READY;
                            end else if (r_cur == D_OVF) begin
                                r_ovr <= inc32(r_ovr);
                                r_lost <= addl(r_lost, LPF);
                            end else begin
                                r_err <= inc32(r_err);
                                r_stat <= ST_BAD_COMPL;
                                r_abort <= 1'b1;
                            end
                        end
                        REQ_ACQUIRE: begin
                            if (!r_found) r_stat <= ST_NONE_READY;
                            else begin
                                r_bst[r_sel] <= B_PACKING;
                                r_bls[r_sel] <= r_lc;
                                r_lc <= (r_lc == {LEASE_W{1'b1}}) ? 32'd1 : r_lc + 1'b1;
                                r_bidx <= DEST_W'(r_sel);
                                r_bfirst <= r_bfs[r_sel];
                                r_lease <= r_lc;
                            end
                        end
                        REQ_RELEASE: begin
                            if (r_req.handle_lease == '0 ||
                                {1'b0, r_req.handle_index} >= (IDX_W+1)'(RING_DEPTH) ||
                                r_bst[PW'(r_req.handle_index)] != B_PACKING ||
                                r_bls[PW'(r_req.handle_index)] != r_req.handle_lease ||
                                LOST_W'(r_bfs[PW'(r_req.handle_index)])
                                    != r_req.handle_first_sample) begin
                                r_stat <= ST_BAD_HANDLE;
                            end else begin
                                r_bst[PW'(r_req.handle_index)] <= B_FREE;
                                r_bls[PW'(r_req.handle_index)] <= '0;
                            end
                        end
                        REQ_STOP: begin
                            logic [ASAMP_W-1:0] smp;
                            logic [ERR_W-1:0] e;
                            smp = r_req.stop_samples;
                            e = r_err;
                            if (smp > ASAMP_W'(SAMPLES_PER_FRAME)) begin
                                smp = ASAMP_W'(SAMPLES_PER_FRAME);
                                e = inc32(e);
                            end
                            if (r_run) begin
                                if (smp != '0) begin
                                    r_lost <= addl(r_lost, LOST_W'(smp));
                                    if (r_cur == D_OVF) r_ovr <= inc32(r_ovr);
                                end
                                if (r_cur < D_OVF) begin
                                    if (r_bst[w_cur] != B_ACTIVE) e = inc32(e);
                                    r_bst[w_cur] <= B_FREE;
                                    r_bls[w_cur] <= '0;
                                end
                                if (r_nxt < D_OVF) begin
                                    if (r_bst[w_nxt] != B_QUEUED) e = inc32(e);
                                    r_bst[w_nxt] <= B_FREE;
                                end
                                r_run <= 1'b0;
                                r_cur <= D_NONE;
                                r_nxt <= D_NONE;
                            end
                            r_err <= e;
                        end
                        default: ;
                    endcase
                end
                OP_TAKE1, OP_TAKE2: begin
                    // prime takes active then queued, at fixed indices zero and one
                    if (r_stat == ST_OK) begin
                        if (r_ffound) begin
                            r_bst[r_fsel] <= (i_cmd.op == OP_TAKE1) ? B_ACTIVE : B_QUEUED;
                            r_bfs[r_fsel] <= (i_cmd.op == OP_TAKE1) ? r_curf : r_nxtf;
                            r_bls[r_fsel] <= '0;
                            r_sptr <= incp(r_fsel);
                            if (i_cmd.op == OP_TAKE1) r_cur <= DEST_W'(r_fsel);
                            else r_nxt <= DEST_W'(r_fsel);
                        end else begin
                            if (i_cmd.op == OP_TAKE1) r_cur <= D_OVF;
                            else r_nxt <= D_OVF;
                        end
                    end
                end
                OP_FRAME2: begin
                    if (!r_abort) begin
                        r_cur <= r_nxt;
                        r_curf <= r_nxtf;
                        if (r_nxt < D_OVF && r_bst[w_nxt] != B_QUEUED) begin
                            r_err <= inc32(r_err);
                            r_stat <= ST_BAD_COMPL;
                        end else if (r_nxt > D_OVF) begin
                            r_err <= inc32(r_err);
                            r_stat <= ST_BAD_COMPL;
                        end else begin
                            if (r_nxt < D_OVF) r_bst[w_nxt] <= B_ACTIVE;
                            r_nxtf <= r_futf;
                            r_futf <= adds(r_futf);
                            if (r_ffound) begin
                                r_bst[r_fsel] <= B_QUEUED;
                                r_bfs[r_fsel] <= r_futf;
                                r_bls[r_fsel] <= '0;
                                r_sptr <= incp(r_fsel);
                                r_nxt <= DEST_W'(r_fsel);
                            end else r_nxt <= D_OVF;
                        end
                    end
                end
                OP_COUNT: begin
                    r_i <= o_sts.count_done ? '0 : r_i + 1'b1;
                    if (r_i == '0) begin
                        r_nrdy <= CW'(r_bst[w_i] == B_READY);
                        r_npk  <= CW'(r_bst[w_i] == B_PACKING);
                    end else begin
                        r_nrdy <= r_nrdy + CW'(r_bst[w_i] == B_READY);
                        r_npk  <= r_npk + CW'(r_bst[w_i] == B_PACKING);
                    end
                end
                default: ;
            endcase
            // free search for take and promote operations, one entry per cycle during scan
            if (i_cmd.op == OP_SCAN || i_cmd.op == OP_EXEC) begin
                logic [PW-1:0] c;
                c = (i_cmd.op == OP_SCAN) ? w_fc : '0;
                if (i_cmd.op == OP_SCAN && !r_ffound && r_bst[c] == B_FREE) begin
                    r_ffound <= 1'b1;
                    r_fsel <= c;
                end
                // prime: all free, first two indices from zero
                if (i_cmd.op == OP_EXEC && r_req.req_type == REQ_PRIME) begin
                    r_ffound <= 1'b1;
                    r_fsel <= '0;
                end
            end
            if (i_cmd.op == OP_TAKE1) r_fsel <= PW'(1);
        end
    end

    always_comb begin
        o_rsp.status = r_stat;
        o_rsp.active_dest = r_cur;
        o_rsp.queued_dest = r_nxt;
        o_rsp.dest_index = r_bidx;
        o_rsp.start_sample = HFIRST_W'(r_bfirst);
        o_rsp.lease_id = r_lease;
        o_rsp.ready_count = CNT_W'(r_nrdy);
        o_rsp.busy_count = CNT_W'(r_npk);
        o_rsp.running = r_run;
        o_rsp.fault_count = r_err;
        o_rsp.overruns = r_ovr;
        o_rsp.lost_total = r_lost;
    end
endmodule

>>> rtl/core/dma_capture_buffer_ring_manager_unit.sv
// dma capture buffer ring manager
// in channel carries one request word (prime, frame complete, acquire,
// release, stop) with handle fields and stop sample count
// out channel returns one result word per request: status, dma
// destinations, handed-out buffer, counts and saturating counters
// a request is accepted in an idle cycle, then goes through a buffer scan
// over every ring entry, an execute step, a take of the active then the
// queued buffer on prime or a promote step on frame complete, then state
// counting over every entry, after which the result word is offered
// one request is in flight at a time; input is not ready until the result
// is taken
// reset frees all buffers, stops capture, sets both destinations to none
// and the lease counter to one
// when the receiver stalls the result is held and no request is accepted
module dma_capture_buffer_ring_manager_unit #(
    parameter int RING_DEPTH        = 8,
    parameter int SAMPLES_PER_FRAME = 1024,
    parameter int SAMPLE_BITS       = 48
) (
    input logic i_clk,
    input logic i_rst_n,
    dcbrm_if.sink   i_req,
    dcbrm_if.source o_rsp
);
    import dcbrm_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic [2:0] w_rt;
    t_rsp w_rsp;

    dcbrm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_req.valid), .o_in_ready(i_req.ready),
        .o_out_valid(o_rsp.valid), .i_out_ready(o_rsp.ready),
        .i_req_type(w_rt), .i_sts(w_sts), .o_cmd(w_cmd)
    );

    dcbrm_dp #(
        .RING_DEPTH(RING_DEPTH), .SAMPLES_PER_FRAME(SAMPLES_PER_FRAME),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(i_req.data), .i_cmd(w_cmd),
        .o_sts(w_sts), .o_req_type(w_rt), .o_rsp(w_rsp)
    );

    assign o_rsp.data = w_rsp;
endmodule
